[src/rlpe_pkg.sv]
// ----------------------------------------------------------------------------
// rlpe_pkg
// Shared types and constants for the RGB LED pulse encoder.
// ----------------------------------------------------------------------------
package rlpe_pkg;

    localparam int SLOTS_PER_BIT    = 10;
    localparam int LONG_HIGH_SLOTS  = 5;
    localparam int SHORT_HIGH_SLOTS = 3;
    localparam int BITS_PER_PIXEL   = 24;
    localparam int SYM_CNT_W        = $clog2(BITS_PER_PIXEL);

    localparam logic [8:0]  BRIGHTNESS_RESET   = 9'd256;
    localparam logic [8:0]  BRIGHTNESS_FULL    = 9'd256;
    localparam logic [15:0] SLOT_DIVIDER_RESET = 16'd13;

    // register indexes (byte address / 4)
    localparam logic REG_BRIGHTNESS   = 1'b0;
    localparam logic REG_SLOT_DIVIDER = 1'b1;

    localparam logic [2:0] HIGH_SLOTS_ONE  = 3'(LONG_HIGH_SLOTS);
    localparam logic [2:0] HIGH_SLOTS_ZERO = 3'(SHORT_HIGH_SLOTS);
    localparam logic [2:0] LOW_SLOTS_ONE   = 3'(SLOTS_PER_BIT - LONG_HIGH_SLOTS);
    localparam logic [2:0] LOW_SLOTS_ZERO  = 3'(SLOTS_PER_BIT - SHORT_HIGH_SLOTS);

    localparam logic [SYM_CNT_W-1:0] SYM_LAST = SYM_CNT_W'(BITS_PER_PIXEL - 1);

    typedef struct packed {
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
    } scaled_pixel_t;

endpackage

[src/rgb_led_pulse_encoder_core.sv]
// ----------------------------------------------------------------------------
// rgb_led_pulse_encoder_core
// A pixel's first symbol is valid once the pixel has passed the lane stage
// and then the shifter. The shifter gives one symbol per cycle while m_tready
// is high; the lane stage takes the next pixel while the current one shifts out.
// Reset: asynchronous, active low; brightness returns to 256, slot_divider
// to 13, and both pipeline stages empty.
// ----------------------------------------------------------------------------
module rgb_led_pulse_encoder_core
    import rlpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    // symbol output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // bit_value[0], high_slots[3:1], low_slots[6:4], 0[7]
    output logic        m_tlast,   // last_bit
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [8:0]    brightness_reg;
    logic [15:0]   slot_divider_reg;
    logic          cfg_wr;
    logic          lane_valid_reg;
    logic          lane_valid_next;
    logic          lane_load;
    logic          pix_ready;
    scaled_pixel_t pix;
    logic          sym_bit;
    logic [2:0]    sym_high;
    logic [2:0]    sym_low;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg   <= BRIGHTNESS_RESET;
            slot_divider_reg <= SLOT_DIVIDER_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_BRIGHTNESS:   brightness_reg   <= pwdata[8:0];
                REG_SLOT_DIVIDER: slot_divider_reg <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_BRIGHTNESS:   prdata = 32'(brightness_reg);
            REG_SLOT_DIVIDER: prdata = 32'(slot_divider_reg);
            default:          prdata = '0;
        endcase
    end

    // lane stage: hold a scaled pixel until the shifter takes it
    assign s_tready        = !lane_valid_reg || pix_ready;
    assign lane_load       = s_tvalid && s_tready;
    assign lane_valid_next = lane_load || (lane_valid_reg && !pix_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg <= 1'b0;
        end
        else
        begin
            lane_valid_reg <= lane_valid_next;
        end
    end

    rlpe_lane u_lane_red
    (
        .clk        (clk),
        .load       (lane_load),
        .chan       (s_tdata[7:0]),
        .brightness (brightness_reg),
        .scaled     (pix.red)
    );

    rlpe_lane u_lane_green
    (
        .clk        (clk),
        .load       (lane_load),
        .chan       (s_tdata[15:8]),
        .brightness (brightness_reg),
        .scaled     (pix.green)
    );

    rlpe_lane u_lane_blue
    (
        .clk        (clk),
        .load       (lane_load),
        .chan       (s_tdata[23:16]),
        .brightness (brightness_reg),
        .scaled     (pix.blue)
    );

    rlpe_serializer u_serializer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (lane_valid_reg),
        .pix_ready (pix_ready),
        .pix       (pix),
        .sym_valid (m_tvalid),
        .sym_ready (m_tready),
        .sym_bit   (sym_bit),
        .sym_high  (sym_high),
        .sym_low   (sym_low),
        .sym_last  (m_tlast)
    );

    assign m_tdata = {1'b0, sym_low, sym_high, sym_bit};

endmodule

[src/rlpe_lane.sv]
// ----------------------------------------------------------------------------
// rlpe_lane
// One color lane: scales a channel byte by brightness / 256, registered.
// ----------------------------------------------------------------------------
module rlpe_lane
    import rlpe_pkg::*;
(
    input  logic       clk,
    input  logic       load,
    input  logic [7:0] chan,
    input  logic [8:0] brightness,
    output logic [7:0] scaled
);

    logic [8:0]  bright_clamped;
    logic [16:0] product;
    logic [7:0]  scaled_reg;
    logic [7:0]  scaled_next;

    // anything at or above full scale acts as full scale
    assign bright_clamped = brightness[8] ? BRIGHTNESS_FULL : brightness;
    assign product        = 17'(chan) * 17'(bright_clamped);
    assign scaled_next    = product[15:8];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            scaled_reg <= scaled_next;
        end
    end

    assign scaled = scaled_reg;

endmodule

[src/rlpe_serializer.sv]
// ----------------------------------------------------------------------------
// rlpe_serializer
// Merges the lane results into a GRB word and shifts it out MSB first,
// one pulse symbol per transaction.
// ----------------------------------------------------------------------------
module rlpe_serializer
    import rlpe_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pix_valid,
    output logic          pix_ready,
    input  scaled_pixel_t pix,
    output logic          sym_valid,
    input  logic          sym_ready,
    output logic          sym_bit,
    output logic [2:0]    sym_high,
    output logic [2:0]    sym_low,
    output logic          sym_last
);

    logic                           busy_reg;
    logic                           busy_next;
    logic [SYM_CNT_W-1:0]           cnt_reg;
    logic [SYM_CNT_W-1:0]           cnt_next;
    logic [BITS_PER_PIXEL-1:0]      shift_reg;
    logic [BITS_PER_PIXEL-1:0]      shift_next;
    logic                           sym_done;
    logic                           load;

    assign sym_done  = busy_reg && sym_ready;
    assign pix_ready = !busy_reg || (sym_ready && (cnt_reg == SYM_LAST));
    assign load      = pix_valid && pix_ready;

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        if (load)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = pix;
        end
        else if (sym_done)
        begin
            if (cnt_reg == SYM_LAST)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next   = cnt_reg + SYM_CNT_W'(1);
                shift_next = {shift_reg[BITS_PER_PIXEL-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign sym_valid = busy_reg;
    assign sym_bit   = shift_reg[BITS_PER_PIXEL-1];
    assign sym_high  = sym_bit ? HIGH_SLOTS_ONE : HIGH_SLOTS_ZERO;
    assign sym_low   = sym_bit ? LOW_SLOTS_ONE : LOW_SLOTS_ZERO;
    assign sym_last  = (cnt_reg == SYM_LAST);

endmodule

[test/tb_rgb_led_pulse_encoder_core.sv]
// ----------------------------------------------------------------------------
// tb_rgb_led_pulse_encoder_core
// Self-checking bench for the RGB LED pulse encoder. Pixels stream in with
// bursty gaps and the symbol stream drains into a sink that stalls on its
// own pattern. Every symbol is checked against an expected scaled-GRB word. The
// brightness and slot divider registers are rewritten between phases and
// read back, so the run covers dark, full and over-range brightness.
// ----------------------------------------------------------------------------
module tb_rgb_led_pulse_encoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rlpe_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_PIXELS   = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 200;

    typedef struct packed {
        logic       bit_value;
        logic [2:0] high_slots;
        logic [2:0] low_slots;
        logic       last_bit;
    } symbol_t;

    typedef enum logic {
        ROW_PIXEL,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        reg_idx;
        logic [31:0] value;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        typed;
        logic [23:0] grb;
    } plan_row_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_BLOCKS
    } sink_mode_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;    // red[7:0], green[15:8], blue[23:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // bit_value[0], high_slots[3:1], low_slots[6:4], 0[7]
    logic        m_tlast;          // last_bit
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    symbol_t     symbols_due[$];
    logic [8:0]  brightness_q = BRIGHTNESS_RESET;
    logic [15:0] slot_div_q   = SLOT_DIVIDER_RESET;

    int errors        = 0;
    int reports       = 0;
    int pixels_sent   = 0;
    int symbols_seen  = 0;
    int writes_done   = 0;
    int cycle_count   = 0;
    int burst_left    = 0;
    int sink_cycle    = 0;
    int sink_hold     = 0;
    sink_mode_t sink_mode = SINK_OPEN;

    rgb_led_pulse_encoder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // Predictor: scale one channel, saturating the factor at full scale.
    function automatic logic [7:0] scale_channel(input logic [7:0] chan);
        logic [8:0]  factor;
        logic [16:0] product;
        factor  = (brightness_q > BRIGHTNESS_FULL) ? BRIGHTNESS_FULL : brightness_q;
        product = 17'(chan) * 17'(factor);
        return product[15:8];
    endfunction

    function automatic logic [23:0] scaled_grb(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
        return {scale_channel(g), scale_channel(r), scale_channel(b)};
    endfunction

    // Expand a GRB word into its symbols, MSB first.
    function automatic void queue_symbols(input logic [23:0] word);
        symbol_t sym;
        int      high;
        for (int k = 0; k < BITS_PER_PIXEL; k++)
        begin
            sym.bit_value  = word[BITS_PER_PIXEL - 1 - k];
            high           = sym.bit_value ? LONG_HIGH_SLOTS : SHORT_HIGH_SLOTS;
            sym.high_slots = 3'(high);
            sym.low_slots  = 3'(SLOTS_PER_BIT - high);
            sym.last_bit   = (k == BITS_PER_PIXEL - 1);
            symbols_due.push_back(sym);
        end
    endfunction

    function automatic plan_row_t pixel_row(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input logic typed,
                                            input logic [23:0] grb);
        plan_row_t row;
        row       = '0;
        row.kind  = ROW_PIXEL;
        row.red   = r;
        row.green = g;
        row.blue  = b;
        row.typed = typed;
        row.grb   = grb;
        return row;
    endfunction

    function automatic plan_row_t write_row(input logic idx, input logic [31:0] value);
        plan_row_t row;
        row         = '0;
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.value   = value;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        errors++;
        if (reports < MAX_REPORTS)
        begin
            reports++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // Called at a falling edge; return at the falling edge after the transaction.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic typed, input logic [23:0] typed_grb);
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        queue_symbols(typed ? typed_grb : scaled_grb(r, g, b));
        pixels_sent++;
        @(negedge clk);
    endtask

    // Drop valid between bursts; leave it high when no gap is drawn.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (symbols_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Write one register, then read it back.
    task automatic cfg_write(input logic idx, input logic [31:0] value);
        logic [31:0] stored;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_BRIGHTNESS)
            brightness_q = value[8:0];
        else
            slot_div_q = value[15:0];
        stored = (idx == REG_BRIGHTNESS) ? {23'd0, brightness_q} : {16'd0, slot_div_q};
        writes_done++;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== stored)
            report_mismatch(idx == REG_BRIGHTNESS ? "brightness readback"
                                                  : "slot_divider readback", stored, prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Sink: switch stall pattern every so often.
    always @(negedge clk)
    begin
        if (sink_cycle % 101 == 0)
            sink_mode = sink_mode_t'($urandom_range(0, 3));
        sink_cycle++;
        case (sink_mode)
            SINK_OPEN:   m_tready <= 1'b1;
            SINK_COIN:   m_tready <= 1'($urandom_range(0, 1));
            SINK_SPARSE: m_tready <= (sink_cycle % 5 == 0);
            default:
            begin
                if (sink_hold > 0)
                begin
                    sink_hold--;
                    m_tready <= 1'b0;
                end
                else
                begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        sink_hold = $urandom_range(3, 12);
                end
            end
        endcase
    end

    always @(posedge clk)
    begin : symbol_check
        symbol_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            symbols_seen++;
            if (symbols_due.size() == 0)
                report_mismatch("unexpected symbol", 32'd0, {23'd0, m_tlast, m_tdata});
            else
            begin
                want = symbols_due.pop_front();
                if (m_tdata[0] !== want.bit_value)
                    report_mismatch("bit_value", 32'(want.bit_value), 32'(m_tdata[0]));
                if (m_tdata[3:1] !== want.high_slots)
                    report_mismatch("high_slots", 32'(want.high_slots), 32'(m_tdata[3:1]));
                if (m_tdata[6:4] !== want.low_slots)
                    report_mismatch("low_slots", 32'(want.low_slots), 32'(m_tdata[6:4]));
                if (m_tlast !== want.last_bit)
                    report_mismatch("last_bit", 32'(want.last_bit), 32'(m_tlast));
            end
        end
    end

    initial
    begin : stimulus
        plan_row_t   plan[$];
        plan_row_t   row;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [31:0] wdata;
        logic [8:0]  level;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        plan.push_back(pixel_row(8'h00, 8'h00, 8'h00, 1'b1, 24'h000000));
        plan.push_back(pixel_row(8'hff, 8'hff, 8'hff, 1'b1, 24'hffffff));
        plan.push_back(pixel_row(8'hff, 8'h00, 8'h00, 1'b1, 24'h00ff00));
        plan.push_back(pixel_row(8'h00, 8'hff, 8'h00, 1'b1, 24'hff0000));
        plan.push_back(pixel_row(8'h00, 8'h00, 8'hff, 1'b1, 24'h0000ff));
        plan.push_back(pixel_row(8'ha5, 8'h3c, 8'h81, 1'b1, 24'h3ca581));
        plan.push_back(pixel_row(8'h5a, 8'hc3, 8'h7e, 1'b0, 24'h0));
        // dark: everything scales to zero
        plan.push_back(write_row(REG_BRIGHTNESS, 32'd0));
        plan.push_back(pixel_row(8'hff, 8'hff, 8'hff, 1'b1, 24'h000000));
        plan.push_back(pixel_row(8'ha5, 8'h3c, 8'h81, 1'b1, 24'h000000));
        plan.push_back(write_row(REG_BRIGHTNESS, 32'd128));
        plan.push_back(pixel_row(8'hff, 8'hff, 8'hff, 1'b1, 24'h7f7f7f));
        plan.push_back(pixel_row(8'h01, 8'h02, 8'h03, 1'b0, 24'h0));
        // above full scale saturates to 256
        plan.push_back(write_row(REG_BRIGHTNESS, 32'd300));
        plan.push_back(pixel_row(8'hff, 8'h80, 8'h01, 1'b1, 24'h80ff01));
        plan.push_back(write_row(REG_BRIGHTNESS, 32'd511));
        plan.push_back(pixel_row(8'hff, 8'hff, 8'hff, 1'b1, 24'hffffff));
        plan.push_back(write_row(REG_BRIGHTNESS, 32'd1));
        plan.push_back(pixel_row(8'hff, 8'hff, 8'hff, 1'b1, 24'h000000));
        plan.push_back(write_row(REG_BRIGHTNESS, 32'd255));
        plan.push_back(pixel_row(8'hff, 8'hff, 8'hff, 1'b1, 24'hfefefe));
        // slot divider does not change the symbols, including zero
        plan.push_back(write_row(REG_SLOT_DIVIDER, 32'd0));
        plan.push_back(pixel_row(8'h12, 8'h34, 8'h56, 1'b0, 24'h0));
        plan.push_back(write_row(REG_SLOT_DIVIDER, 32'd65535));
        plan.push_back(write_row(REG_SLOT_DIVIDER, 32'd1));
        plan.push_back(write_row(REG_BRIGHTNESS, 32'd256));
        plan.push_back(pixel_row(8'hc8, 8'h64, 8'h32, 1'b0, 24'h0));

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == ROW_WRITE)
            begin
                wait_idle();
                cfg_write(row.reg_idx, row.value);
            end
            else
            begin
                pace_sender();
                send_pixel(row.red, row.green, row.blue, row.typed, row.grb);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0:       level = 9'd256;
                1:       level = 9'd0;
                2:       level = 9'($urandom_range(1, 255));
                3:       level = 9'd511;
                4:       level = 9'($urandom_range(257, 511));
                5:       level = 9'd1;
                default: level = 9'($urandom_range(0, 511));
            endcase
            // junk in the unused upper bits half the time
            wdata      = ($urandom_range(0, 1) != 0) ? $urandom() : 32'd0;
            wdata[8:0] = level;
            cfg_write(REG_BRIGHTNESS, wdata);
            wdata = ($urandom_range(0, 1) != 0) ? $urandom() : 32'd0;
            case (phase)
                0:       wdata[15:0] = 16'd0;
                1:       wdata[15:0] = 16'hffff;
                2:       wdata[15:0] = 16'd1;
                default: wdata[15:0] = 16'($urandom());
            endcase
            cfg_write(REG_SLOT_DIVIDER, wdata);

            for (int n = 0; n < PHASE_PIXELS; n++)
            begin
                case ($urandom_range(0, 9))
                    6:
                    begin
                        r = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
                        g = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
                        b = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
                    end
                    7:
                    begin
                        r = 8'(1 << $urandom_range(0, 7));
                        g = 8'(1 << $urandom_range(0, 7));
                        b = 8'(1 << $urandom_range(0, 7));
                    end
                    default:
                    begin
                        r = 8'($urandom());
                        g = 8'($urandom());
                        b = 8'($urandom());
                    end
                endcase
                pace_sender();
                send_pixel(r, g, b, 1'b0, 24'h0);
            end
        end

        wait_idle();
        $display("covered %0d pixels, %0d symbols checked, %0d register writes read back",
                 pixels_sent, symbols_seen, writes_done);
        $display("brightness swept dark, minimum, mid, full and saturated; both sides stalled");
        if (errors == 0 && symbols_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
src/rlpe_pkg.sv
src/rlpe_lane.sv
src/rlpe_serializer.sv
src/rgb_led_pulse_encoder_core.sv
test/tb_rgb_led_pulse_encoder_core.sv
